// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define MRF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, held off during reset.
`define MRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ----- hdl/mrf_pkg.sv -----
// Package for the Modbus RTU request framer: payload types, codes and constants.
`timescale 1ns / 1ps
package mrf_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam logic [6:0]  MaxWriteWords     = 7'd123;
  localparam logic [6:0]  ReadLimit         = 7'd125;
  localparam logic [15:0] CrcInit           = 16'hFFFF;
  localparam logic [15:0] CrcPoly           = 16'hA001;

  localparam logic [7:0] FnReadHolding  = 8'h03;
  localparam logic [7:0] FnReadInput    = 8'h04;
  localparam logic [7:0] FnWriteSingle  = 8'h06;
  localparam logic [7:0] FnWriteMulti   = 8'h10;

  typedef enum logic [2:0] {
    REQ_READ_HOLD    = 3'd0,
    REQ_READ_INPUT   = 3'd1,
    REQ_WRITE_SINGLE = 3'd2,
    REQ_WRITE_MULTI  = 3'd3,
    REQ_DATA_WORD    = 3'd4
  } req_type_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic [6:0]  reg_count;
    logic [15:0] data_word;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic       error;
  } rsp_t;

  // One classified item, as queued between front and back.
  typedef struct packed {
    logic            err;      // rejected: one error result only
    logic            start;    // opens a new frame, CRC restarts
    logic            crc_en;   // append CRC after the data bytes
    logic [2:0]      n_bytes;  // data bytes in use, 1..7
    logic [6:0][7:0] bytes;    // bytes[0] goes out first
  } cmd_t;

endpackage

// ----- hdl/mrf_front.sv -----
// Front end: classifies request items, tracks owed data words, builds byte commands.
`timescale 1ns / 1ps
module mrf_front import mrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic push_o,
  output cmd_t cmd_o,
  input  logic full_i
);

  logic [6:0] words_owed_q, words_owed_d;
  logic       accept;

  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept;

  always_comb begin
    cmd_o        = '0;
    words_owed_d = words_owed_q;
    if (in_data_i.req_type > REQ_DATA_WORD) begin
      cmd_o.err = 1'b1;
    end else if (in_data_i.req_type != REQ_DATA_WORD && words_owed_q != 7'd0) begin
      cmd_o.err = 1'b1;
    end else begin
      unique case (req_type_e'(in_data_i.req_type))
        REQ_READ_HOLD, REQ_READ_INPUT: begin
          if (in_data_i.reg_count > ReadLimit) begin
            cmd_o.err = 1'b1;
          end else begin
            cmd_o.start    = 1'b1;
            cmd_o.crc_en   = 1'b1;
            cmd_o.n_bytes  = 3'd6;
            cmd_o.bytes[0] = in_data_i.slave_addr;
            cmd_o.bytes[1] = (in_data_i.req_type == REQ_READ_HOLD) ? FnReadHolding
                                                                    : FnReadInput;
            cmd_o.bytes[2] = in_data_i.reg_addr[15:8];
            cmd_o.bytes[3] = in_data_i.reg_addr[7:0];
            cmd_o.bytes[4] = 8'd0;
            cmd_o.bytes[5] = {1'b0, in_data_i.reg_count};
          end
        end
        REQ_WRITE_SINGLE: begin
          cmd_o.start    = 1'b1;
          cmd_o.crc_en   = 1'b1;
          cmd_o.n_bytes  = 3'd6;
          cmd_o.bytes[0] = in_data_i.slave_addr;
          cmd_o.bytes[1] = FnWriteSingle;
          cmd_o.bytes[2] = 8'd0;
          cmd_o.bytes[3] = in_data_i.reg_addr[7:0];
          cmd_o.bytes[4] = 8'd0;
          cmd_o.bytes[5] = in_data_i.data_word[7:0];
        end
        REQ_WRITE_MULTI: begin
          if (in_data_i.reg_count > MaxWriteWords) begin
            cmd_o.err = 1'b1;
          end else begin
            cmd_o.start    = 1'b1;
            cmd_o.crc_en   = (in_data_i.reg_count == 7'd0);
            cmd_o.n_bytes  = 3'd7;
            cmd_o.bytes[0] = in_data_i.slave_addr;
            cmd_o.bytes[1] = FnWriteMulti;
            cmd_o.bytes[2] = in_data_i.reg_addr[15:8];
            cmd_o.bytes[3] = in_data_i.reg_addr[7:0];
            cmd_o.bytes[4] = 8'd0;
            cmd_o.bytes[5] = {1'b0, in_data_i.reg_count};
            cmd_o.bytes[6] = {in_data_i.reg_count, 1'b0};
            words_owed_d   = in_data_i.reg_count;
          end
        end
        REQ_DATA_WORD: begin
          if (words_owed_q == 7'd0) begin
            cmd_o.err = 1'b1;
          end else begin
            cmd_o.crc_en   = (words_owed_q == 7'd1);
            cmd_o.n_bytes  = 3'd2;
            cmd_o.bytes[0] = in_data_i.data_word[15:8];
            cmd_o.bytes[1] = in_data_i.data_word[7:0];
            words_owed_d   = words_owed_q - 7'd1;
          end
        end
        default: cmd_o.err = 1'b1;
      endcase
    end
    // a rejected item emits a single zero byte and leaves the state alone
    if (cmd_o.err) begin
      cmd_o.n_bytes = 3'd1;
      cmd_o.bytes   = '0;
      cmd_o.start   = 1'b0;
      cmd_o.crc_en  = 1'b0;
      words_owed_d  = words_owed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_owed_q <= 7'd0;
    end else if (accept) begin
      words_owed_q <= words_owed_d;
    end
  end

endmodule

// ----- hdl/mrf_queue.sv -----
// Short command queue between front and back end.
`timescale 1ns / 1ps
module mrf_queue import mrf_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/mrf_back.sv -----
// Back end: walks queued commands byte by byte, keeps the running CRC, output register.
`timescale 1ns / 1ps
module mrf_back import mrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic empty_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  logic [15:0] crc_q, crc_d, crc_base;
  logic [3:0]  idx_q, idx_d, total;
  logic        out_valid_q;
  rsp_t        out_q, out_d;
  logic        load, is_last, in_data;
  logic [7:0]  cur_byte;

  assign load    = ~empty_i & (~out_valid_q | ~out_stall_i);
  assign total   = {1'b0, cmd_i.n_bytes} + (cmd_i.crc_en ? 4'd2 : 4'd0);
  assign is_last = (idx_q == total - 4'd1);
  assign in_data = (idx_q < {1'b0, cmd_i.n_bytes});
  assign pop_o   = load & is_last;

  always_comb begin
    crc_base = (cmd_i.start && idx_q == 4'd0) ? CrcInit : crc_q;
    if (cmd_i.err) begin
      cur_byte = 8'd0;
    end else if (in_data) begin
      cur_byte = cmd_i.bytes[idx_q[2:0]];
    end else if (idx_q == {1'b0, cmd_i.n_bytes}) begin
      cur_byte = crc_q[7:0];
    end else begin
      cur_byte = crc_q[15:8];
    end

    crc_d = crc_q;
    if (load && !cmd_i.err) begin
      if (in_data) begin
        crc_d = crc_byte(crc_base, cur_byte);
      end else if (is_last) begin
        crc_d = CrcInit;   // CRC high byte out, frame closed
      end
    end

    idx_d = idx_q;
    if (load) begin
      idx_d = is_last ? 4'd0 : idx_q + 4'd1;
    end

    out_d.tx_byte = cur_byte;
    out_d.last    = is_last;
    out_d.error   = cmd_i.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q <= crc_d;
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/modbus_rtu_request_framer_top.sv -----
// Top level of the Modbus RTU request framer.
`timescale 1ns / 1ps
// Turns request items into Modbus RTU master frame bytes with a CRC-16 (init 0xFFFF,
// poly 0xA001) appended low byte first. One output transfer carries one byte; an item
// gives 1 to 9 bytes (reads and write single 8, a write multiple header 7, or 9 with a
// zero count, a data word 2, or 4 with the CRC of the final word, a rejected item one
// error result). The back end emits one byte per cycle while the output is not stalled;
// this single byte path is what sets the sustained rate. The front end
// takes an item in any cycle while the command queue (QueueDepth entries) has room, so
// input transfers go on while earlier items are still being sent.
module modbus_rtu_request_framer_top import mrf_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  cmd_t push_cmd, head_cmd;
  logic push, pop, full, empty;

  mrf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  mrf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .full_o      (full),
    .empty_o     (empty)
  );

  mrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/mrf_checker.sv -----
// Port-level checks for the Modbus RTU request framer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mrf_checker import mrf_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input req_t in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_data_o
);

  logic out_held, out_err, in_held;
  assign out_held = out_valid_o & out_stall_i;
  assign out_err  = out_valid_o & out_data_o.error;
  assign in_held  = in_valid_i & in_stall_o;

  // an error result stands alone for its item
  `MRF_ASSERT_IMPL(a_err_last, clk_i, rst_ni, out_err, out_data_o.last)
  `MRF_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_err, out_data_o.tx_byte == 8'd0)
  `MRF_ASSERT_NEXT(a_out_hold_valid, clk_i, rst_ni, out_held, out_valid_o)
  `MRF_ASSERT_NEXT(a_out_hold_data, clk_i, rst_ni, out_held, $stable(out_data_o))
  // a stalled input transfer is held by the sender
  `MRF_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_held, in_valid_i && $stable(in_data_i))

endmodule

bind modbus_rtu_request_framer_top mrf_checker u_mrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
